FILE: hw/rtl/swl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sound register write logger.
// Used by swl_front, swl_queue, swl_back and sound_register_write_logger.

package swl_pkg;

    // Width of the pending wait count, which saturates at its top value.
    localparam int WAIT_BITS = 20;

    // Request codes on the cmd field.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Command stream bytes.
    localparam logic [7:0] OP_END       = 8'h66;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
    localparam logic [3:0] OP_WAIT_SHORT_HI = 4'h7;
    localparam logic [7:0] OP_WAIT_LONG = 8'h61;
    localparam logic [7:0] OP_REG_WRITE = 8'hB9;

    // Wait lengths of the one-byte wait commands and the largest long-wait chunk.
    localparam int WAIT_NTSC_LEN  = 735;
    localparam int WAIT_PAL_LEN   = 882;
    localparam int WAIT_SHORT_MAX = 16;
    localparam int WAIT_CHUNK     = 65535;

    // Register window of the sound chip.
    localparam logic [15:0] REG_BASE = 16'h0800;
    localparam logic [15:0] REG_TOP  = 16'h0809;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic [WAIT_BITS-1:0] wait_count;  // wait to flush first
        logic                 has_write;   // emit a register write after the wait
        logic                 is_stop;     // emit the end byte after the wait
        logic [3:0]           reg_index;
        logic [7:0]           reg_data;
        logic [31:0]          total;       // sample total for the end byte
    } job_t;

    // Byte sequencer states of the back part.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT_CMD,
        ST_WAIT_LO,
        ST_WAIT_HI,
        ST_REG_CMD,
        ST_REG_IDX,
        ST_REG_DATA,
        ST_END
    } back_state_t;

endpackage

FILE: hw/rtl/sound_register_write_logger.sv
`timescale 1ns / 1ps
// Top level of the sound register write logger: front, job queue and back.
// Depends on swl_pkg, swl_front, swl_queue and swl_back.
//
//  Channel   Handshake                Payload
//  request   item_valid / item_stall  cmd, tick_samples, reg_address, reg_value
//  output    byte_valid / byte_stall  out_byte, last, sample_total
//
// A request is taken whenever the two-entry job queue has room;
// start, tick and ignored requests never occupy the queue.
// The back sequencer loads a job in its idle state, then emits one byte per
// cycle while the output is not stalled.
// Reset clears recording state, queue and sequencer; the block is ready at once.
// Output stalls hold the output register and back up into the queue.

module sound_register_write_logger (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] tick_samples,
    input  logic [15:0] reg_address,
    input  logic [7:0]  reg_value,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [31:0] sample_total
);

    swl_pkg::job_t new_job;
    swl_pkg::job_t head_job;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // Request decoding and recording state.
    swl_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .cmd             (cmd),
        .tick_samples    (tick_samples),
        .reg_address     (reg_address),
        .reg_value       (reg_value),
        .q_full          (q_full),
        .push            (push),
        .job             (new_job)
    );

    // Job queue between the two sides.
    swl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Byte stream sequencer.
    swl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_job     (head_job),
        .pop          (pop),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .out_byte     (out_byte),
        .last         (last),
        .sample_total (sample_total)
    );

endmodule

FILE: hw/rtl/swl_front.sv
`timescale 1ns / 1ps
// Front part: accepts requests, keeps the recording state and turns each
// request that causes output into a job. Depends on swl_pkg.

module swl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            cmd,
    input  logic [15:0]           tick_samples,
    input  logic [15:0]           reg_address,
    input  logic [7:0]            reg_value,
    input  logic                  q_full,
    output logic                  push,
    output swl_pkg::job_t         job
);

    logic                          recording_reg, recording_next;
    logic [swl_pkg::WAIT_BITS-1:0] pending_reg, pending_next;
    logic [31:0]                   seen_reg, seen_next;

    logic                          accept;
    logic [swl_pkg::WAIT_BITS:0]   wait_sum;
    logic                          in_window;

    // Requests wait while the queue has no room.
    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    assign wait_sum  = {1'b0, pending_reg}
                     + (swl_pkg::WAIT_BITS + 1)'(tick_samples);
    assign in_window = (reg_address >= swl_pkg::REG_BASE)
                    && (reg_address <= swl_pkg::REG_TOP);

    // Classify the request and update the recording state.
    always_comb
    begin
        recording_next  = recording_reg;
        pending_next    = pending_reg;
        seen_next       = seen_reg;
        push            = 1'b0;
        job.wait_count  = pending_reg;
        job.has_write   = 1'b0;
        job.is_stop     = 1'b0;
        job.reg_index   = reg_address[3:0];
        job.reg_data    = reg_value;
        job.total       = 32'd0;
        if (accept)
        begin
            unique case (cmd)
                swl_pkg::CMD_START:
                begin
                    if (!recording_reg)
                    begin
                        recording_next = 1'b1;
                        pending_next   = '0;
                        seen_next      = 32'd0;
                    end
                end
                swl_pkg::CMD_TICK:
                begin
                    if (recording_reg)
                    begin
                        // Saturate the wait on carry out of its width.
                        pending_next = wait_sum[swl_pkg::WAIT_BITS]
                                     ? '1 : wait_sum[swl_pkg::WAIT_BITS-1:0];
                        seen_next    = seen_reg + 32'(tick_samples);
                    end
                end
                swl_pkg::CMD_WRITE:
                begin
                    if (recording_reg)
                    begin
                        job.has_write = in_window;
                        push          = in_window || (pending_reg != '0);
                        pending_next  = '0;
                    end
                end
                swl_pkg::CMD_STOP:
                begin
                    if (recording_reg)
                    begin
                        job.is_stop    = 1'b1;
                        job.total      = seen_reg;
                        push           = 1'b1;
                        pending_next   = '0;
                        recording_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Recording state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recording_reg <= 1'b0;
            pending_reg   <= '0;
            seen_reg      <= 32'd0;
        end
        else
        begin
            recording_reg <= recording_next;
            pending_reg   <= pending_next;
            seen_reg      <= seen_next;
        end
    end

endmodule

FILE: hw/rtl/swl_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front and the back part.
// Depends on swl_pkg for the job type.

module swl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  swl_pkg::job_t push_job,
    input  logic          pop,
    output swl_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);

    swl_pkg::job_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hw/rtl/swl_back.sv
`timescale 1ns / 1ps
// Back part: takes jobs from the queue and emits their command bytes one
// at a time through an output register. Depends on swl_pkg.

module swl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  swl_pkg::job_t head_job,
    output logic          pop,
    output logic          byte_valid,
    input  logic          byte_stall,
    output logic [7:0]    out_byte,
    output logic          last,
    output logic [31:0]   sample_total
);

    swl_pkg::back_state_t          state_reg, state_next;
    logic [swl_pkg::WAIT_BITS-1:0] wait_reg, wait_next;
    logic [15:0]                   chunk_reg, chunk_next;
    logic                          has_write_reg, has_write_next;
    logic                          is_stop_reg, is_stop_next;
    logic [3:0]                    index_reg, index_next;
    logic [7:0]                    data_reg, data_next;
    logic [31:0]                   total_reg, total_next;

    logic                          valid_reg, valid_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          last_reg, last_next;
    logic [31:0]                   sum_out_reg, sum_out_next;

    logic                          advance;
    swl_pkg::back_state_t          post_wait;
    swl_pkg::back_state_t          after_hi;
    logic [4:0]                    short_code;

    assign byte_valid   = valid_reg;
    assign out_byte     = byte_reg;
    assign last         = last_reg;
    assign sample_total = sum_out_reg;

    // The output register can take a new byte when empty or being taken.
    assign advance = !valid_reg || !byte_stall;

    // What follows once the wait of the current job is flushed.
    always_comb
    begin
        if (has_write_reg)
        begin
            post_wait = swl_pkg::ST_REG_CMD;
        end
        else if (is_stop_reg)
        begin
            post_wait = swl_pkg::ST_END;
        end
        else
        begin
            post_wait = swl_pkg::ST_IDLE;
        end
        after_hi = (wait_reg != '0) ? swl_pkg::ST_WAIT_CMD : post_wait;
    end

    assign short_code = wait_reg[4:0] - 5'd1;

    // Byte sequencer.
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        chunk_next     = chunk_reg;
        has_write_next = has_write_reg;
        is_stop_next   = is_stop_reg;
        index_next     = index_reg;
        data_next      = data_reg;
        total_next     = total_reg;
        valid_next     = advance ? 1'b0 : valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        sum_out_next   = sum_out_reg;
        pop            = 1'b0;

        unique case (state_reg)
            swl_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop            = 1'b1;
                    wait_next      = head_job.wait_count;
                    has_write_next = head_job.has_write;
                    is_stop_next   = head_job.is_stop;
                    index_next     = head_job.reg_index;
                    data_next      = head_job.reg_data;
                    total_next     = head_job.total;
                    if (head_job.wait_count != '0)
                    begin
                        state_next = swl_pkg::ST_WAIT_CMD;
                    end
                    else if (head_job.has_write)
                    begin
                        state_next = swl_pkg::ST_REG_CMD;
                    end
                    else if (head_job.is_stop)
                    begin
                        state_next = swl_pkg::ST_END;
                    end
                    else
                    begin
                        state_next = swl_pkg::ST_IDLE;
                    end
                end
            end
            swl_pkg::ST_WAIT_CMD:
            begin
                if (advance)
                begin
                    valid_next   = 1'b1;
                    sum_out_next = 32'd0;
                    last_next    = 1'b0;
                    // Pick the shortest command for the remaining wait.
                    priority if (wait_reg == swl_pkg::WAIT_BITS'(swl_pkg::WAIT_NTSC_LEN))
                    begin
                        byte_next  = swl_pkg::OP_WAIT_NTSC;
                        wait_next  = '0;
                        state_next = post_wait;
                        last_next  = (post_wait == swl_pkg::ST_IDLE);
                    end
                    else if (wait_reg == swl_pkg::WAIT_BITS'(swl_pkg::WAIT_PAL_LEN))
                    begin
                        byte_next  = swl_pkg::OP_WAIT_PAL;
                        wait_next  = '0;
                        state_next = post_wait;
                        last_next  = (post_wait == swl_pkg::ST_IDLE);
                    end
                    else if (wait_reg <= swl_pkg::WAIT_BITS'(swl_pkg::WAIT_SHORT_MAX))
                    begin
                        byte_next  = {swl_pkg::OP_WAIT_SHORT_HI, short_code[3:0]};
                        wait_next  = '0;
                        state_next = post_wait;
                        last_next  = (post_wait == swl_pkg::ST_IDLE);
                    end
                    else if (wait_reg <= swl_pkg::WAIT_BITS'(swl_pkg::WAIT_CHUNK))
                    begin
                        byte_next  = swl_pkg::OP_WAIT_LONG;
                        chunk_next = wait_reg[15:0];
                        wait_next  = '0;
                        state_next = swl_pkg::ST_WAIT_LO;
                    end
                    else
                    begin
                        byte_next  = swl_pkg::OP_WAIT_LONG;
                        chunk_next = 16'(swl_pkg::WAIT_CHUNK);
                        wait_next  = wait_reg - swl_pkg::WAIT_BITS'(swl_pkg::WAIT_CHUNK);
                        state_next = swl_pkg::ST_WAIT_LO;
                    end
                end
            end
            swl_pkg::ST_WAIT_LO:
            begin
                if (advance)
                begin
                    valid_next   = 1'b1;
                    byte_next    = chunk_reg[7:0];
                    last_next    = 1'b0;
                    sum_out_next = 32'd0;
                    state_next   = swl_pkg::ST_WAIT_HI;
                end
            end
            swl_pkg::ST_WAIT_HI:
            begin
                if (advance)
                begin
                    valid_next   = 1'b1;
                    byte_next    = chunk_reg[15:8];
                    last_next    = (after_hi == swl_pkg::ST_IDLE);
                    sum_out_next = 32'd0;
                    state_next   = after_hi;
                end
            end
            swl_pkg::ST_REG_CMD:
            begin
                if (advance)
                begin
                    valid_next   = 1'b1;
                    byte_next    = swl_pkg::OP_REG_WRITE;
                    last_next    = 1'b0;
                    sum_out_next = 32'd0;
                    state_next   = swl_pkg::ST_REG_IDX;
                end
            end
            swl_pkg::ST_REG_IDX:
            begin
                if (advance)
                begin
                    valid_next   = 1'b1;
                    byte_next    = {4'd0, index_reg};
                    last_next    = 1'b0;
                    sum_out_next = 32'd0;
                    state_next   = swl_pkg::ST_REG_DATA;
                end
            end
            swl_pkg::ST_REG_DATA:
            begin
                if (advance)
                begin
                    valid_next   = 1'b1;
                    byte_next    = data_reg;
                    last_next    = 1'b1;
                    sum_out_next = 32'd0;
                    state_next   = swl_pkg::ST_IDLE;
                end
            end
            swl_pkg::ST_END:
            begin
                if (advance)
                begin
                    valid_next   = 1'b1;
                    byte_next    = swl_pkg::OP_END;
                    last_next    = 1'b1;
                    sum_out_next = total_reg;
                    state_next   = swl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swl_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Job and output payload registers.
    always_ff @(posedge clk)
    begin
        wait_reg      <= wait_next;
        chunk_reg     <= chunk_next;
        has_write_reg <= has_write_next;
        is_stop_reg   <= is_stop_next;
        index_reg     <= index_next;
        data_reg      <= data_next;
        total_reg     <= total_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        sum_out_reg   <= sum_out_next;
    end

endmodule

FILE: tb/sound_register_write_logger_tb.sv
`timescale 1ns / 1ps
// Testbench of the sound register write logger: directed and random requests are
// predicted in place and every output byte is checked against the prediction.
// Depends on swl_pkg and sound_register_write_logger.

module sound_register_write_logger_tb;

    // One predicted byte of the command stream.
    typedef struct packed {
        logic [7:0]  code;
        logic        last;
        logic [31:0] total;
    } stream_byte_t;

    localparam logic [swl_pkg::WAIT_BITS-1:0] WAIT_CEILING = '1;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  cmd;
    logic [15:0] tick_samples;
    logic [15:0] reg_address;
    logic [7:0]  reg_value;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] sample_total;

    // Predicted recording state of the logger.
    logic                          rec_on;
    logic [swl_pkg::WAIT_BITS-1:0] wait_owed;
    logic [31:0]                   total_seen;

    stream_byte_t bytes_due[$];
    stream_byte_t burst[$];

    int mismatches;
    bit sender_quiet;
    bit receiver_quiet;
    bit byte_go;
    int stall_left;

    sound_register_write_logger dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .cmd             (cmd),
        .tick_samples    (tick_samples),
        .reg_address     (reg_address),
        .reg_value       (reg_value),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .out_byte        (out_byte),
        .last            (last),
        .sample_total    (sample_total)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog against a hung stream.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Appends one byte to the burst of the request being predicted.
    function automatic void put_code(input logic [7:0] code, input logic [31:0] total);
        stream_byte_t b;
        b.code  = code;
        b.last  = 1'b0;
        b.total = total;
        burst = {burst, b};
    endfunction

    // Turns the owed wait into wait commands and clears it.
    function automatic void flush_wait_owed();
        int unsigned left;
        left = wait_owed;
        while (left > 0)
        begin
            if (left == swl_pkg::WAIT_NTSC_LEN)
            begin
                put_code(swl_pkg::OP_WAIT_NTSC, 32'd0);
                left = 0;
            end
            else if (left == swl_pkg::WAIT_PAL_LEN)
            begin
                put_code(swl_pkg::OP_WAIT_PAL, 32'd0);
                left = 0;
            end
            else if (left <= swl_pkg::WAIT_SHORT_MAX)
            begin
                put_code({swl_pkg::OP_WAIT_SHORT_HI, 4'(left - 1)}, 32'd0);
                left = 0;
            end
            else if (left <= swl_pkg::WAIT_CHUNK)
            begin
                put_code(swl_pkg::OP_WAIT_LONG, 32'd0);
                put_code(left[7:0], 32'd0);
                put_code(left[15:8], 32'd0);
                left = 0;
            end
            else
            begin
                put_code(swl_pkg::OP_WAIT_LONG, 32'd0);
                put_code(8'hFF, 32'd0);
                put_code(8'hFF, 32'd0);
                left = left - swl_pkg::WAIT_CHUNK;
            end
        end
        wait_owed = '0;
    endfunction

    // Updates the recording state for one accepted request and queues its bytes.
    function automatic void predict_request(input logic [1:0] c, input logic [15:0] es,
                                            input logic [15:0] addr, input logic [7:0] val);
        logic [32:0] sum;
        burst.delete();
        if (c == swl_pkg::CMD_START)
        begin
            if (!rec_on)
            begin
                rec_on     = 1'b1;
                wait_owed  = '0;
                total_seen = '0;
            end
        end
        else if (rec_on)
        begin
            if (c == swl_pkg::CMD_TICK)
            begin
                sum        = 33'(wait_owed) + 33'(es);
                wait_owed  = (sum > 33'(WAIT_CEILING))
                           ? WAIT_CEILING : sum[swl_pkg::WAIT_BITS-1:0];
                total_seen = total_seen + 32'(es);
            end
            else if (c == swl_pkg::CMD_WRITE)
            begin
                flush_wait_owed();
                if (addr >= swl_pkg::REG_BASE && addr <= swl_pkg::REG_TOP)
                begin
                    put_code(swl_pkg::OP_REG_WRITE, 32'd0);
                    put_code(8'(addr - swl_pkg::REG_BASE), 32'd0);
                    put_code(val, 32'd0);
                end
            end
            else
            begin
                flush_wait_owed();
                put_code(swl_pkg::OP_END, total_seen);
                rec_on = 1'b0;
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            bytes_due = {bytes_due, burst};
        end
    endfunction

    // Sends one request after a random gap; called and returning at a rising edge.
    task automatic send_request(input logic [1:0] c, input logic [15:0] es,
                                input logic [15:0] addr, input logic [7:0] val);
        int gap;
        bit taken;
        gap = sender_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        cmd          <= c;
        tick_samples <= es;
        reg_address  <= addr;
        reg_value    <= val;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        predict_request(c, es, addr, val);
    endtask

    // Holds requests back until every predicted byte has come out.
    task automatic wait_for_stream_drain();
        item_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Compares one accepted output byte with the oldest prediction.
    task automatic check_stream_byte();
        stream_byte_t want;
        if (bytes_due.size() == 0)
            report_mismatch($sformatf("unexpected byte %h", out_byte));
        else
        begin
            want = bytes_due.pop_front();
            if (out_byte !== want.code)
                report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.code));
            if (last !== want.last)
                report_mismatch($sformatf("last %b on byte %h, want %b",
                                          last, want.code, want.last));
            if (sample_total !== want.total)
                report_mismatch($sformatf("sample_total %h on byte %h, want %h",
                                          sample_total, want.code, want.total));
        end
    endtask

    // Output monitor: a byte moves at the next edge when valid and not stalled.
    initial
    begin
        byte_go = 1'b0;
        forever
        begin
            @(negedge clk);
            byte_go = rst_n && byte_valid && !byte_stall;
            if (byte_go)
                check_stream_byte();
        end
    end

    // Output stall: after each accepted byte, stall for a random number of cycles.
    initial
    begin
        byte_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (byte_go)
                stall_left = receiver_quiet ? 0 : $urandom_range(0, 7);
            if (stall_left > 0)
            begin
                byte_stall <= 1'b1;
                stall_left--;
            end
            else
                byte_stall <= 1'b0;
        end
    end

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 16));
            1: return ($urandom_range(0, 1) == 0) ? 16'(swl_pkg::WAIT_NTSC_LEN)
                                                  : 16'(swl_pkg::WAIT_PAL_LEN);
            2: return 16'($urandom_range(17, 1000));
            3: return 16'(swl_pkg::WAIT_CHUNK);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 3))
            0, 1: return swl_pkg::REG_BASE + 16'($urandom_range(0, 9));
            2: return ($urandom_range(0, 1) == 0) ? swl_pkg::REG_BASE - 16'd1
                                                  : swl_pkg::REG_TOP + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Tick, write and stop before any start must be dropped.
    task automatic test_idle_requests();
        send_request(swl_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_BASE, 8'h12);
        send_request(swl_pkg::CMD_STOP, 16'h1234, 16'h0000, 8'h00);
        wait_for_stream_drain();
    endtask

    // Each wait encoding, the register window edges and a second start.
    task automatic test_wait_codes();
        send_request(swl_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_START, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_request(swl_pkg::CMD_TICK, 16'(swl_pkg::WAIT_NTSC_LEN), 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_BASE, 8'hFF);
        send_request(swl_pkg::CMD_TICK, 16'(swl_pkg::WAIT_PAL_LEN), 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_WRITE, 16'hFFFF, swl_pkg::REG_TOP, 8'h00);
        send_request(swl_pkg::CMD_TICK, 16'd1, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_BASE - 16'd1, 8'hAA);
        send_request(swl_pkg::CMD_TICK, 16'd16, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_TOP + 16'd1, 8'h55);
        send_request(swl_pkg::CMD_TICK, 16'd17, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_BASE + 16'd5, 8'h5A);
        send_request(swl_pkg::CMD_TICK, 16'hFFFF, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_TICK, 16'hFFFF, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_TICK, 16'd3, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_BASE + 16'd1, 8'hA5);
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_BASE + 16'd3, 8'h3C);
        send_request(swl_pkg::CMD_TICK, 16'd0, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_STOP, 16'h0000, 16'h0000, 8'h00);
        wait_for_stream_drain();
    endtask

    // Drives the owed wait into saturation and flushes it in full-length chunks and a short remainder.
    task automatic test_wait_saturation();
        send_request(swl_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
        sender_quiet = 1'b1;
        repeat (17) send_request(swl_pkg::CMD_TICK, 16'hFFFF, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_TICK, 16'd2, 16'h0000, 8'h00);
        sender_quiet = 1'b0;
        send_request(swl_pkg::CMD_WRITE, 16'h0000, swl_pkg::REG_BASE + 16'd2, 8'hC3);
        send_request(swl_pkg::CMD_TICK, 16'd5, 16'h0000, 8'h00);
        send_request(swl_pkg::CMD_STOP, 16'h0000, 16'h0000, 8'h00);
        wait_for_stream_drain();
    endtask

    // Recording sessions with random content, some noise and some drains.
    task automatic test_random_sessions();
        int sent;
        int pairs;
        int ticks;
        sent = 0;
        while (sent < 50)
        begin
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                send_request(2'($urandom_range(1, 3)), 16'($urandom), 16'($urandom),
                             8'($urandom));
                sent++;
            end
            send_request(swl_pkg::CMD_START, 16'($urandom), 16'($urandom), 8'($urandom));
            sent++;
            if ($urandom_range(0, 9) == 0)
            begin
                ticks = $urandom_range(17, 20);
                repeat (ticks) send_request(swl_pkg::CMD_TICK,
                                            16'($urandom_range(60000, 65535)),
                                            16'($urandom), 8'($urandom));
                sent += ticks;
            end
            pairs = $urandom_range(1, 6);
            repeat (pairs)
            begin
                ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1;
                repeat (ticks) send_request(swl_pkg::CMD_TICK, pick_elapsed(),
                                            16'($urandom), 8'($urandom));
                if ($urandom_range(0, 9) == 0)
                begin
                    send_request(swl_pkg::CMD_START, 16'($urandom), 16'($urandom),
                                 8'($urandom));
                    sent++;
                end
                send_request(swl_pkg::CMD_WRITE, 16'($urandom), pick_address(),
                             8'($urandom));
                sent += ticks + 1;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_request(swl_pkg::CMD_TICK, pick_elapsed(), 16'($urandom),
                                 8'($urandom));
                    sent++;
                end
                send_request(swl_pkg::CMD_STOP, 16'($urandom), 16'($urandom), 8'($urandom));
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_stream_drain();
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
    endtask

    // Reset, the tests in turn, then the final verdict.
    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        cmd            = swl_pkg::CMD_START;
        tick_samples   = '0;
        reg_address    = '0;
        reg_value      = '0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        mismatches     = 0;
        rec_on         = 1'b0;
        wait_owed      = '0;
        total_seen     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_requests();
        test_wait_codes();
        test_wait_saturation();
        test_random_sessions();
        wait_for_stream_drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/swl_pkg.sv
hw/rtl/swl_front.sv
hw/rtl/swl_queue.sv
hw/rtl/swl_back.sv
hw/rtl/sound_register_write_logger.sv
tb/sound_register_write_logger_tb.sv
